/* hdl/mmws_pkg.sv */
// Package for the multi-mode waveshaper: curve codes, fixed-point constants,
// the wide working type, rounding and the builder for the exponential nodes.
// Depends on nothing.
package mmws_pkg;

	localparam int FRAC_BITS = 20;
	localparam int WIDE_BITS = 68;

	typedef logic signed [WIDE_BITS-1:0] wide_t;

	localparam logic [2:0] MODE_HARD  = 3'd0;
	localparam logic [2:0] MODE_SOFT  = 3'd1;
	localparam logic [2:0] MODE_EXP   = 3'd2;
	localparam logic [2:0] MODE_FULL  = 3'd3;
	localparam logic [2:0] MODE_HALF  = 3'd4;
	localparam logic [2:0] MODE_ARAYA = 3'd5;
	localparam logic [2:0] MODE_SYM   = 3'd6;
	localparam logic [2:0] MODE_ASYM  = 3'd7;
	localparam logic [2:0] MODE_RESET = MODE_FULL;

	localparam longint ONE_Q      = 64'sd1048576;
	localparam longint HALF_Q     = 64'sd524288;
	localparam longint EXP_SPAN_Q = 64'sd8388608;
	localparam longint unsigned FRAC_MASK   = 64'd1048575;
	localparam longint unsigned EXP_M1_Q30  = 64'd395007542;
	// floor(n/3) equals (n * DIV3_RECIP) >> 21 for every n below 2^21.
	localparam longint DIV3_RECIP = 64'sd699051;
	localparam longint ASYM_NEG_KNEE = 64'sd93376;
	localparam longint ASYM_POS_KNEE = 64'sd335564;
	localparam longint ASYM_TOP      = 64'sd660640;
	localparam longint ASYM_OFFSET   = 64'sd34443;
	localparam longint ASYM_BIAS     = 64'sd10486;
	localparam longint ASYM_QUAD     = 64'sd6451888;
	localparam longint ASYM_LIN      = 64'sd4128768;

	// Right shift that rounds to nearest, ties away from zero.
	function automatic wide_t rnd_shift(input wide_t v, input int unsigned n);
		wide_t half;
		half = wide_t'(1) <<< (n - 1);
		if (v >= 0)
			return (v + half) >>> n;
		return -((-v + half) >>> n);
	endfunction

	// e^-t in Q30 for t in Q20, built as (e^-1)^n times a Taylor series of e^-f.
	function automatic longint unsigned neg_exp_q30(input longint unsigned t);
		longint unsigned n;
		longint unsigned f;
		longint unsigned term;
		longint unsigned sum;
		n = t >> FRAC_BITS;
		f = t & FRAC_MASK;
		term = 64'd1 << 30;
		sum = term;
		term = ((term * f) >> FRAC_BITS) / 64'd1;  sum = sum - term;
		term = ((term * f) >> FRAC_BITS) / 64'd2;  sum = sum + term;
		term = ((term * f) >> FRAC_BITS) / 64'd3;  sum = sum - term;
		term = ((term * f) >> FRAC_BITS) / 64'd4;  sum = sum + term;
		term = ((term * f) >> FRAC_BITS) / 64'd5;  sum = sum - term;
		term = ((term * f) >> FRAC_BITS) / 64'd6;  sum = sum + term;
		term = ((term * f) >> FRAC_BITS) / 64'd7;  sum = sum - term;
		term = ((term * f) >> FRAC_BITS) / 64'd8;  sum = sum + term;
		term = ((term * f) >> FRAC_BITS) / 64'd9;  sum = sum - term;
		term = ((term * f) >> FRAC_BITS) / 64'd10; sum = sum + term;
		term = ((term * f) >> FRAC_BITS) / 64'd11; sum = sum - term;
		term = ((term * f) >> FRAC_BITS) / 64'd12; sum = sum + term;
		term = ((term * f) >> FRAC_BITS) / 64'd13; sum = sum - term;
		term = ((term * f) >> FRAC_BITS) / 64'd14; sum = sum + term;
		for (int i = 0; i < 8; i++) begin
			if (longint'(i) < longint'(n))
				sum = (sum * EXP_M1_Q30) >> 30;
		end
		return sum;
	endfunction

endpackage

/* hdl/multi_mode_waveshaper.sv */
// Multi-mode waveshaper: eight distortion curves on a Q3.20 sample, pipelined.
// Uses mmws_pkg for curve codes, constants, rounding and the exponential nodes.
//
// Channel   Direction  Handshake                 Payload
// input     in         start (busy is always 0)  sample_in
// result    out        strobe, one cycle         sample_out
// config    in         cfg_valid / cfg_ready     shaper_mode
//
// A sample taken at one edge runs down the result line and comes out on
// sample_out, marked by strobe; a new sample may be started at every edge.
// The depth is set by the asymmetric curve, whose twelfth power takes one
// multiply per stage.
// Reset clears the valid bits and sets the curve to the full-wave rectifier.
// Nothing can stall the pipeline, so busy stays low and cfg_ready stays high.
module multi_mode_waveshaper #(
	parameter int SAMPLE_BITS     = 24,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          strobe,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    shaper_mode
);

	localparam int SB  = SAMPLE_BITS;
	localparam int LAT = 13;
	localparam int KW  = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int PW  = 24 + KW;
	localparam int MMW = 2 * SB + 1;
	localparam int X2W = 2 * SB - 20;
	localparam int HW  = (SB > 20) ? SB - 20 : 1;
	localparam int PHW = X2W + HW;
	localparam int PLW = X2W + 20;

	function automatic logic signed [SB-1:0] sat_fn(input mmws_pkg::wide_t v);
		mmws_pkg::wide_t hi;
		mmws_pkg::wide_t lo;
		hi = (mmws_pkg::wide_t'(1) <<< (SB - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi[SB-1:0];
		if (v < lo)
			return lo[SB-1:0];
		return v[SB-1:0];
	endfunction

	logic [2:0]               mode_q;
	logic                     vld_s [1:LAT];
	logic [2:0]               mode_s [1:LAT];
	logic signed [SB-1:0]     res_s [2:LAT];
	logic signed [SB-1:0]     x_s1;

	assign busy       = 1'b0;
	assign cfg_ready  = 1'b1;
	assign strobe     = vld_s[LAT];
	assign sample_out = res_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mmws_pkg::MODE_RESET;
			for (int i = 1; i <= LAT; i++)
				vld_s[i] <= 1'b0;
		end else begin
			if (cfg_valid)
				mode_q <= shaper_mode;
			vld_s[1] <= start;
			for (int i = 2; i <= LAT; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		x_s1      <= sample_in;
		mode_s[1] <= mode_q;
		for (int i = 2; i <= LAT; i++)
			mode_s[i] <= mode_s[i-1];
	end

	// ---------------------------------------------------------------- stage 2
	mmws_pkg::wide_t xw, mw, r2w, tw, soft_t3;
	logic [SB-1:0]        m_u;
	logic                 soft_quad;
	logic [20:0]          soft_d;
	logic [23:0]          exp_a;
	logic signed [21:0]   asym_xc;
	logic                 asym_neg, asym_mid;
	logic [19:0]          asym_u;

	always_comb begin
		xw = mmws_pkg::wide_t'(x_s1);
		mw = (xw < 0) ? -xw : xw;
		m_u = mw[SB-1:0];
		soft_t3 = 3 * xw;
		soft_quad = (3 * mw > mmws_pkg::ONE_Q) && !(soft_t3 > 2 * mmws_pkg::ONE_Q)
			&& !(soft_t3 < -2 * mmws_pkg::ONE_Q);
		tw = 2 * mmws_pkg::ONE_Q - 3 * mw;
		soft_d = tw[20:0];
		exp_a = (mw > mmws_pkg::EXP_SPAN_Q) ? 24'd8388608 : mw[23:0];
		if (xw > mmws_pkg::ONE_Q)
			tw = mmws_pkg::ONE_Q;
		else if (xw < -mmws_pkg::ONE_Q)
			tw = -mmws_pkg::ONE_Q;
		else
			tw = xw;
		asym_xc = tw[21:0];
		asym_neg = tw <= -mmws_pkg::ASYM_NEG_KNEE;
		asym_mid = !asym_neg && (tw < mmws_pkg::ASYM_POS_KNEE);
		tw = -tw - mmws_pkg::ASYM_OFFSET;
		asym_u = tw[19:0];
		case (mode_s[1])
			mmws_pkg::MODE_HARD: begin
				if (xw > mmws_pkg::HALF_Q)
					r2w = mmws_pkg::HALF_Q;
				else if (xw < -mmws_pkg::HALF_Q)
					r2w = -mmws_pkg::HALF_Q;
				else
					r2w = xw;
			end
			mmws_pkg::MODE_SOFT: begin
				if (soft_t3 > 2 * mmws_pkg::ONE_Q)
					r2w = mmws_pkg::HALF_Q;
				else if (soft_t3 < -2 * mmws_pkg::ONE_Q)
					r2w = -mmws_pkg::HALF_Q;
				else
					r2w = xw;
			end
			mmws_pkg::MODE_FULL: r2w = mw;
			mmws_pkg::MODE_HALF: r2w = (xw > 0) ? xw : '0;
			mmws_pkg::MODE_ASYM: r2w = mmws_pkg::ASYM_TOP;
			default:             r2w = '0;
		endcase
	end

	// ----------------------------------------------------------- soft clip
	logic        soft_quad_s2, soft_quad_s3, soft_quad_s4;
	logic        soft_neg_s2, soft_neg_s3, soft_neg_s4;
	logic [20:0] soft_d_s2;
	logic [41:0] soft_dd_s3;
	logic [40:0] soft_q_s4;
	logic [20:0] soft_n;
	mmws_pkg::wide_t soft_r;

	always_comb begin
		soft_n = 21'((soft_dd_s3 + 42'd3145728) >> 21);
		soft_r = mmws_pkg::HALF_Q - mmws_pkg::wide_t'(soft_q_s4 >> 21);
		if (soft_neg_s4)
			soft_r = -soft_r;
	end

	always_ff @(posedge clk) begin
		soft_quad_s2 <= soft_quad;
		soft_neg_s2  <= x_s1[SB-1];
		soft_d_s2    <= soft_d;
		soft_quad_s3 <= soft_quad_s2;
		soft_neg_s3  <= soft_neg_s2;
		soft_dd_s3   <= 42'(soft_d_s2) * 42'(soft_d_s2);
		soft_quad_s4 <= soft_quad_s3;
		soft_neg_s4  <= soft_neg_s3;
		soft_q_s4    <= 41'(soft_n) * 41'(mmws_pkg::DIV3_RECIP);
	end

	// --------------------------------------------------------- exponential
	logic [30:0]        exp_rom [0:EXP_TABLE_DEPTH];
	logic [PW-1:0]      exp_p_s2;
	logic               exp_pos_s2, exp_pos_s3, exp_pos_s4;
	logic [KW-1:0]      exp_k, exp_kn;
	logic [30:0]        exp_e0_s3, exp_e1_s3, exp_e0_s4;
	logic [22:0]        exp_rem_s3;
	logic signed [55:0] exp_prod_s4;
	logic signed [31:0] exp_diff;
	mmws_pkg::wide_t    exp_e, exp_r;

	for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_exp_rom
		localparam longint unsigned NODE_T = (64'(g) << 23) / EXP_TABLE_DEPTH;
		assign exp_rom[g] = 31'(mmws_pkg::neg_exp_q30(NODE_T));
	end

	always_comb begin
		exp_k  = KW'(exp_p_s2 >> 23);
		exp_kn = (exp_k == KW'(EXP_TABLE_DEPTH)) ? exp_k : exp_k + 1'b1;
		exp_diff = $signed({1'b0, exp_e0_s3}) - $signed({1'b0, exp_e1_s3});
		exp_e = mmws_pkg::wide_t'(exp_e0_s4)
			- mmws_pkg::rnd_shift(mmws_pkg::wide_t'(exp_prod_s4), 23);
		exp_r = mmws_pkg::ONE_Q - mmws_pkg::rnd_shift(exp_e, 10);
		if (!exp_pos_s4)
			exp_r = -exp_r;
	end

	always_ff @(posedge clk) begin
		exp_p_s2    <= PW'(exp_a) * PW'(EXP_TABLE_DEPTH);
		exp_pos_s2  <= xw > 0;
		exp_e0_s3   <= exp_rom[exp_k];
		exp_e1_s3   <= exp_rom[exp_kn];
		exp_rem_s3  <= exp_p_s2[22:0];
		exp_pos_s3  <= exp_pos_s2;
		exp_e0_s4   <= exp_e0_s3;
		exp_prod_s4 <= 56'(exp_diff) * 56'($signed({1'b0, exp_rem_s3}));
		exp_pos_s4  <= exp_pos_s3;
	end

	// ---------------------------------------------------- symmetric Doidic
	logic [SB-1:0]     sym_m_s2;
	logic [2*SB-1:0]   sym_mm_s2;
	logic              sym_neg_s2;
	mmws_pkg::wide_t   sym_r;

	always_comb begin
		sym_r = mmws_pkg::rnd_shift((mmws_pkg::wide_t'(sym_m_s2) <<< 21)
			- mmws_pkg::wide_t'(sym_mm_s2), 20);
		if (sym_neg_s2)
			sym_r = -sym_r;
	end

	always_ff @(posedge clk) begin
		sym_m_s2   <= m_u;
		sym_mm_s2  <= (2*SB)'(m_u) * (2*SB)'(m_u);
		sym_neg_s2 <= x_s1[SB-1];
	end

	// ------------------------------------------ cubic, three passes of 3 stages
	logic signed [SB-1:0] cub_y_sa [0:2];
	logic [SB-1:0]        cub_m_sa [0:2];
	logic [2*SB-1:0]      cub_mm_sa [0:2];
	logic signed [SB-1:0] cub_y_sb [0:2];
	logic [PHW-1:0]       cub_ph_sb [0:2];
	logic [PLW-1:0]       cub_pl_sb [0:2];
	logic signed [SB-1:0] cub_y_sc [0:2];

	for (genvar j = 0; j < 3; j++) begin : g_cubic
		logic signed [SB-1:0] y_in;
		logic [SB-1:0]        ym;
		logic [X2W-1:0]       x2;
		logic [HW-1:0]        m_hi;
		logic [19:0]          m_lo;
		mmws_pkg::wide_t      c, t;

		if (j == 0) begin : g_first
			assign y_in = x_s1;
		end else begin : g_next
			assign y_in = cub_y_sc[j-1];
		end

		always_comb begin
			ym   = y_in[SB-1] ? SB'(-y_in) : SB'(y_in);
			x2   = X2W'((MMW'(cub_mm_sa[j]) + MMW'(524288)) >> 20);
			m_hi = HW'(cub_m_sa[j] >> 20);
			m_lo = 20'(cub_m_sa[j]);
			c = mmws_pkg::wide_t'(cub_ph_sb[j])
				+ ((mmws_pkg::wide_t'(cub_pl_sb[j]) + 524288) >>> 20);
			if (cub_y_sb[j] < 0)
				c = -c;
			t = mmws_pkg::rnd_shift(3 * mmws_pkg::wide_t'(cub_y_sb[j]) - c, 1);
		end

		always_ff @(posedge clk) begin
			cub_y_sa[j]  <= y_in;
			cub_m_sa[j]  <= ym;
			cub_mm_sa[j] <= (2*SB)'(ym) * (2*SB)'(ym);
			cub_y_sb[j]  <= cub_y_sa[j];
			cub_ph_sb[j] <= PHW'(x2) * PHW'(m_hi);
			cub_pl_sb[j] <= PLW'(x2) * PLW'(m_lo);
			cub_y_sc[j]  <= sat_fn(t);
		end
	end

	// --------------------------------------------------- asymmetric Doidic
	logic [19:0]          asym_p_s [2:12];
	logic [19:0]          asym_u_s [2:12];
	logic [19:0]          asym_q_s [2:12];
	logic                 asym_neg_s [2:12];
	logic                 asym_mid_s2, asym_mid_s3;
	logic signed [21:0]   asym_xc_s2;
	logic [40:0]          asym_xx_s2;
	logic [63:0]          asym_quad_s3;
	logic signed [44:0]   asym_lin_s3;
	mmws_pkg::wide_t      asym_mid_r, asym_neg_r, asym_sq;

	always_comb begin
		asym_sq = mmws_pkg::wide_t'(asym_xc) * mmws_pkg::wide_t'(asym_xc);
		asym_mid_r = mmws_pkg::rnd_shift((mmws_pkg::wide_t'(asym_lin_s3) <<< 20)
			- mmws_pkg::wide_t'(asym_quad_s3), 40);
		// 0.75 * (p + (u + 1)/3), rounded, as a multiply by 3 and a shift by 2.
		asym_neg_r = mmws_pkg::ASYM_BIAS
			- ((3 * (mmws_pkg::wide_t'(asym_p_s[12]) + mmws_pkg::wide_t'(asym_q_s[12]))
			+ 2) >>> 2);
	end

	always_ff @(posedge clk) begin
		asym_u_s[2]   <= asym_u;
		asym_p_s[2]   <= 20'((40'(asym_u) * 40'(asym_u) + 40'd524288) >> 20);
		asym_q_s[2]   <= 20'(((41'(asym_u) + 41'd1) * 41'(mmws_pkg::DIV3_RECIP)) >> 21);
		asym_neg_s[2] <= asym_neg;
		asym_mid_s2   <= asym_mid;
		asym_xc_s2    <= asym_xc;
		asym_xx_s2    <= asym_sq[40:0];
		asym_mid_s3   <= asym_mid_s2;
		asym_quad_s3  <= 64'(asym_xx_s2) * 64'(mmws_pkg::ASYM_QUAD);
		asym_lin_s3   <= 45'(asym_xc_s2) * 45'(mmws_pkg::ASYM_LIN);
		for (int k = 3; k <= 12; k++) begin
			asym_p_s[k]   <= 20'((40'(asym_p_s[k-1]) * 40'(asym_u_s[k-1])
				+ 40'd524288) >> 20);
			asym_u_s[k]   <= asym_u_s[k-1];
			asym_q_s[k]   <= asym_q_s[k-1];
			asym_neg_s[k] <= asym_neg_s[k-1];
		end
	end

	// --------------------------------------------------------- result line
	// Each curve overwrites the travelling result at the stage where it is done.
	always_ff @(posedge clk) begin
		res_s[2] <= sat_fn(r2w);
		res_s[3] <= (mode_s[2] == mmws_pkg::MODE_SYM) ? sat_fn(sym_r) : res_s[2];
		res_s[4] <= (mode_s[3] == mmws_pkg::MODE_ASYM && asym_mid_s3)
			? sat_fn(asym_mid_r) : res_s[3];
		if (mode_s[4] == mmws_pkg::MODE_SOFT && soft_quad_s4)
			res_s[5] <= sat_fn(soft_r);
		else if (mode_s[4] == mmws_pkg::MODE_EXP)
			res_s[5] <= sat_fn(exp_r);
		else
			res_s[5] <= res_s[4];
		for (int i = 6; i <= 10; i++)
			res_s[i] <= res_s[i-1];
		res_s[11] <= (mode_s[10] == mmws_pkg::MODE_ARAYA) ? cub_y_sc[2] : res_s[10];
		res_s[12] <= res_s[11];
		res_s[13] <= (mode_s[12] == mmws_pkg::MODE_ASYM && asym_neg_s[12])
			? sat_fn(asym_neg_r) : res_s[12];
	end

endmodule

/* tb/mmws_checker.sv */
// Checker for the multi-mode waveshaper: follows the curve register, predicts each
// shaped sample from the accepted input beats and compares the result beats in order.
// Depends on mmws_pkg for the curve codes and the Q3.20 constants.
module mmws_checker #(
	parameter int SAMPLE_BITS     = 24,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          strobe,
	input  logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [2:0]                    shaper_mode,
	output int                            errors,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [2:0] curve;
	logic signed [SAMPLE_BITS-1:0] shaped_q[$];
	longint exp_nodes[EXP_TABLE_DEPTH+1];

	function automatic longint rshift_round(longint v, int n);
		longint half;
		half = longint'(1) <<< (n - 1);
		if (v >= 0)
			return (v + half) >>> n;
		return -((-v + half) >>> n);
	endfunction

	function automatic longint clamp_sample(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	// e^-t in Q30 for t in Q20: powers of e^-1 times a truncated Taylor series.
	function automatic longint decay_q30(longint unsigned t);
		longint unsigned whole;
		longint unsigned fr;
		longint unsigned term;
		longint sum;
		whole = t >> mmws_pkg::FRAC_BITS;
		fr = t & mmws_pkg::FRAC_MASK;
		term = 64'd1 << 30;
		sum = longint'(1) <<< 30;
		for (int i = 1; i <= 14; i++) begin
			term = ((term * fr) >> mmws_pkg::FRAC_BITS) / longint'(i);
			if (i % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		for (longint unsigned i = 0; i < whole; i++)
			sum = longint'((longint'(sum) * mmws_pkg::EXP_M1_Q30) >> 30);
		return sum;
	endfunction

	function automatic longint cubic_step(longint y);
		longint unsigned m;
		longint unsigned half;
		longint unsigned sq;
		longint c;
		m = (y < 0) ? -y : y;
		half = 64'd1 << (mmws_pkg::FRAC_BITS - 1);
		sq = (m * m + half) >> mmws_pkg::FRAC_BITS;
		c = longint'(sq * (m >> mmws_pkg::FRAC_BITS)
			+ ((sq * (m & mmws_pkg::FRAC_MASK) + half) >> mmws_pkg::FRAC_BITS));
		if (y < 0)
			c = -c;
		return clamp_sample(rshift_round(3 * y - c, 1));
	endfunction

	function automatic longint shape_sample(logic [2:0] sel, longint x);
		longint m;
		longint v;
		longint d;
		longint e;
		longint u;
		longint p;
		longint unsigned a;
		longint unsigned pos;
		longint unsigned k;
		longint unsigned rem;
		m = x < 0 ? -x : x;
		case (sel)
			mmws_pkg::MODE_HARD: begin
				return x > mmws_pkg::HALF_Q ? mmws_pkg::HALF_Q
					: (x < -mmws_pkg::HALF_Q ? -mmws_pkg::HALF_Q : x);
			end
			mmws_pkg::MODE_SOFT: begin
				if (3 * x > 2 * mmws_pkg::ONE_Q) return mmws_pkg::HALF_Q;
				if (3 * x < -2 * mmws_pkg::ONE_Q) return -mmws_pkg::HALF_Q;
				if (3 * m > mmws_pkg::ONE_Q) begin
					d = 2 * mmws_pkg::ONE_Q - 3 * m;
					v = mmws_pkg::HALF_Q
						- (d * d + 3 * mmws_pkg::ONE_Q) / (6 * mmws_pkg::ONE_Q);
					return x < 0 ? -v : v;
				end
				return x;
			end
			mmws_pkg::MODE_EXP: begin
				a = (m > mmws_pkg::EXP_SPAN_Q) ? mmws_pkg::EXP_SPAN_Q : m;
				pos = a * EXP_TABLE_DEPTH;
				k = pos >> 23;
				rem = pos & ((64'd1 << 23) - 1);
				e = exp_nodes[k];
				if (rem != 0)
					e = e - rshift_round((e - exp_nodes[k+1]) * longint'(rem), 23);
				v = mmws_pkg::ONE_Q - rshift_round(e, 10);
				return x > 0 ? v : -v;
			end
			mmws_pkg::MODE_FULL: return m;
			mmws_pkg::MODE_HALF: return x > 0 ? x : 0;
			mmws_pkg::MODE_ARAYA: begin
				v = x;
				for (int i = 0; i < 3; i++)
					v = cubic_step(v);
				return v;
			end
			mmws_pkg::MODE_SYM: begin
				v = rshift_round(2 * m * mmws_pkg::ONE_Q - m * m, mmws_pkg::FRAC_BITS);
				return x < 0 ? -v : v;
			end
			default: begin
				if (x > mmws_pkg::ONE_Q) x = mmws_pkg::ONE_Q;
				if (x < -mmws_pkg::ONE_Q) x = -mmws_pkg::ONE_Q;
				if (x <= -mmws_pkg::ASYM_NEG_KNEE) begin
					u = -x - mmws_pkg::ASYM_OFFSET;
					p = u;
					for (int i = 0; i < 11; i++)
						p = (p * u + mmws_pkg::HALF_Q) >>> mmws_pkg::FRAC_BITS;
					return mmws_pkg::ASYM_BIAS
						- rshift_round((p + (u + 1) / 3) * 786432, mmws_pkg::FRAC_BITS);
				end
				if (x < mmws_pkg::ASYM_POS_KNEE)
					return rshift_round(-mmws_pkg::ASYM_QUAD * (x * x)
						+ mmws_pkg::ASYM_LIN * x * mmws_pkg::ONE_Q,
						2 * mmws_pkg::FRAC_BITS);
				return mmws_pkg::ASYM_TOP;
			end
		endcase
	endfunction

	task automatic report_mismatch(string what);
		$display("tb: mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		for (int k = 0; k <= EXP_TABLE_DEPTH; k++)
			exp_nodes[k] = decay_q30((longint'(k) << 23) / EXP_TABLE_DEPTH);
	end

	always @(posedge clk or negedge arst_n) begin
		logic signed [SAMPLE_BITS-1:0] want;
		if (!arst_n) begin
			curve <= mmws_pkg::MODE_RESET;
		end else begin
			if (start && !busy)
				shaped_q.push_back(SAMPLE_BITS'(clamp_sample(shape_sample(curve,
					longint'(sample_in)))));
			if (strobe) begin
				if (shaped_q.size() == 0) begin
					report_mismatch($sformatf("result beat %0d with nothing expected",
						sample_out));
				end else begin
					want = shaped_q.pop_front();
					if (sample_out !== want)
						report_mismatch($sformatf("sample_out %0d, expected %0d",
							sample_out, want));
				end
			end
			if (cfg_valid && cfg_ready)
				curve <= shaper_mode;
			pending = shaped_q.size();
		end
	end

endmodule

/* tb/multi_mode_waveshaper_test.sv */
// Top of the waveshaper testbench: clock, reset, curve settings and sample stimulus.
// Depends on mmws_pkg, the block itself and mmws_checker, which does the comparing.
module multi_mode_waveshaper_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB = 24;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [SB-1:0] sample_in;
	logic strobe;
	logic signed [SB-1:0] sample_out;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] shaper_mode;
	int errors;
	int pending;

	multi_mode_waveshaper #(.SAMPLE_BITS(SB), .EXP_TABLE_DEPTH(256)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample_in(sample_in), .strobe(strobe), .sample_out(sample_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .shaper_mode(shaper_mode)
	);

	mmws_checker #(.SAMPLE_BITS(SB), .EXP_TABLE_DEPTH(256)) u_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample_in(sample_in), .strobe(strobe), .sample_out(sample_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .shaper_mode(shaper_mode),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	// Lets the pipeline drain before the curve register changes.
	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_curve(logic [2:0] sel);
		drain();
		cfg_valid <= 1'b1;
		shaper_mode <= sel;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(logic signed [SB-1:0] x, int idle_pct);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		start <= 1'b1;
		sample_in <= x;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic signed [SB-1:0] random_sample();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return SB'($urandom);
		if (r < 85)
			return SB'($signed($urandom_range(2 * 1572864)) - 1572864);
		return SB'($signed($urandom_range(8192)) - 4096);
	endfunction

	initial begin
		// Region edges: half scale, soft-clip knees, asymmetric knees, unity clamp.
		int edges[] = '{0, 1, -1, 8388607, -8388608, 524288, -524288, 1048576,
			-1048576, 1048577, -1048577, 349525, 349526, 699050, 699051, -699051,
			-93376, -93375, 335563, 335564, 8388606};
		int idle_pcts[3] = '{0, 54, 6};
		logic [2:0] sel;

		arst_n = 1'b0;
		start = 1'b0;
		sample_in = '0;
		cfg_valid = 1'b0;
		shaper_mode = mmws_pkg::MODE_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The curve left by reset is checked before any write.
		foreach (edges[i])
			send_sample(SB'(edges[i]), 0);
		start <= 1'b0;

		for (int ph = 0; ph < 24; ph++) begin
			sel = 3'(ph % 8);
			write_curve(sel);
			if (ph < 8)
				foreach (edges[i])
					send_sample(SB'(edges[i]), idle_pcts[ph / 8]);
			for (int n = 0; n < 56; n++)
				send_sample(random_sample(), idle_pcts[ph / 8]);
			start <= 1'b0;
		end

		drain();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
